FILE: hdl/tmh_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the timer min-heap queue.
// No dependencies.
package tmh_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = 6;
  localparam int CNT_W    = 7;
  localparam int TIME_W   = 48;

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_CANCEL = 2'd1;
  localparam logic [1:0] ACT_EXPIRE = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_UNKNOWN = 2'd2;
  localparam logic [1:0] ST_EMPTY   = 2'd3;

  // write request into the heap slot store
  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  addr;
    logic [TIME_W-1:0] time_val;
    logic [IDX_W-1:0]  owner;
  } heap_wr_t;

endpackage

FILE: hdl/tmh_heap_mem.sv
`timescale 1ns / 1ps
// Heap slot store: expiry time and owning id per slot.
// One write and one registered read per cycle; uses tmh_pkg.
module tmh_heap_mem (
  input  logic                      clk,
  input  tmh_pkg::heap_wr_t         wr,
  input  logic [tmh_pkg::IDX_W-1:0] raddr,
  output logic [tmh_pkg::TIME_W-1:0] rtime,
  output logic [tmh_pkg::IDX_W-1:0]  rowner
);
  import tmh_pkg::*;

  logic [TIME_W-1:0] heap_time  [CAPACITY];
  logic [IDX_W-1:0]  heap_owner [CAPACITY];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      heap_time[wr.addr]  <= wr.time_val;
      heap_owner[wr.addr] <= wr.owner;
    end
    rtime  <= heap_time[raddr];
    rowner <= heap_owner[raddr];
  end

endmodule

FILE: hdl/timer_min_heap.sv
`timescale 1ns / 1ps
// Timer queue kept as a binary min-heap on expiry time.
// Input on s_* (tuser = action, tdata = expiry_time, timer_id); results on m_*.
// s_tready is high only while the block is idle; one item is in work at a time.
// Insert: scans id_busy one id a cycle for the lowest free id, then sifts
// the new entry up, reading the parent (S_SU_RD) and comparing (S_SU_CMP)
// at each level through the heap store port. Cancel: looks up the slot of
// the id, moves the last entry in and sifts it up then down, reading the
// left child, the right child and comparing at each level down. Expire
// pops every entry equal to the current minimum, each pop a sift-down.
// All results of one item are buffered and sent once the heap is settled,
// since each carries the queue state after the step; each result is read
// from the buffer and then held on m_* until m_tready, with tlast on the
// final one. Reset (rst, synchronous) empties the queue and frees every
// id; the slot memories need no clearing. A stalled receiver simply holds
// the current result; no new item is taken until all results are
// transferred.
module timer_min_heap (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [55:0]  s_tdata,   // [47:0] expiry_time, [53:48] timer_id, rest zero
  input  logic [1:0]   s_tuser,   // [1:0] action
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [111:0] m_tdata,   // [1:0] status, [7:2] result_id, [55:8] fired_time,
                                  // [103:56] earliest_time, [104] has_pending,
                                  // [111:105] pending_count
  output logic         m_tlast    // last
);
  import tmh_pkg::*;

  typedef enum logic [15:0] {
    S_IDLE    = 16'h0001,
    S_SCAN    = 16'h0002,
    S_CSLOT   = 16'h0004,
    S_CLAST   = 16'h0008,
    S_SU_RD   = 16'h0010,
    S_SU_CMP  = 16'h0020,
    S_SD_RDL  = 16'h0040,
    S_SD_RDR  = 16'h0080,
    S_SD_CMP  = 16'h0100,
    S_FIN     = 16'h0200,
    S_POP_RD  = 16'h0400,
    S_POP_CHK = 16'h0800,
    S_TOP_RD  = 16'h1000,
    S_TOP_GET = 16'h2000,
    S_OUT_RD  = 16'h4000,
    S_OUT_SHOW = 16'h8000
  } state_t;

  state_t            state;
  logic [1:0]        act;
  logic [TIME_W-1:0] exp_in;
  logic [1:0]        status;
  logic [CNT_W-1:0]  cnt;
  logic [CAPACITY-1:0] id_busy;
  logic [IDX_W-1:0]  scan_idx;
  logic [IDX_W-1:0]  hole;
  logic [TIME_W-1:0] t_cur;
  logic [IDX_W-1:0]  own_cur;
  logic              after_up;
  logic [TIME_W-1:0] l_time;
  logic [IDX_W-1:0]  l_own;
  logic              r_ok;
  logic [TIME_W-1:0] now;
  logic              first;
  logic [CNT_W-1:0]  n_res;
  logic [CNT_W-1:0]  k_res;
  logic [TIME_W-1:0] earl;

  // memories local to this module
  logic [IDX_W-1:0]  id_slot [CAPACITY];
  logic [IDX_W-1:0]  res_buf [CAPACITY];
  logic [IDX_W-1:0]  slot_rd;
  logic [IDX_W-1:0]  res_rd;

  heap_wr_t          hwr;
  logic [IDX_W-1:0]  hraddr;
  logic [TIME_W-1:0] rd_time;
  logic [IDX_W-1:0]  rd_own;

  logic              slot_we;
  logic [IDX_W-1:0]  slot_waddr;
  logic [IDX_W-1:0]  slot_wdata;
  logic              res_we;
  logic [IDX_W-1:0]  res_waddr;
  logic [IDX_W-1:0]  res_wdata;

  logic              s_xfer;
  logic [IDX_W-1:0]  in_id;
  logic [IDX_W-1:0]  parent;
  logic [CNT_W-1:0]  child;
  logic [CNT_W:0]    child_r;
  logic              pick_r;
  logic [TIME_W-1:0] c_time;
  logic [IDX_W-1:0]  c_own;
  logic [IDX_W-1:0]  c_idx;
  logic [CNT_W-1:0]  cnt_dec;

  tmh_heap_mem u_heap (
    .clk   (clk),
    .wr    (hwr),
    .raddr (hraddr),
    .rtime (rd_time),
    .rowner(rd_own)
  );

  assign s_tready = (state == S_IDLE);
  assign s_xfer   = s_tvalid && s_tready;
  assign in_id    = s_tdata[53:48];
  assign parent   = (hole - IDX_W'(1)) >> 1;
  assign child    = {hole, 1'b1};
  assign child_r  = {1'b0, child} + (CNT_W + 1)'(1);
  assign pick_r   = r_ok && (rd_time < l_time);
  assign c_time   = pick_r ? rd_time : l_time;
  assign c_own    = pick_r ? rd_own : l_own;
  assign c_idx    = pick_r ? child_r[IDX_W-1:0] : child[IDX_W-1:0];
  assign cnt_dec  = cnt - CNT_W'(1);

  // memory port control
  always_comb begin
    hwr        = '0;
    hraddr     = '0;
    slot_we    = 1'b0;
    slot_waddr = '0;
    slot_wdata = '0;
    res_we     = 1'b0;
    res_waddr  = '0;
    res_wdata  = '0;
    unique case (state)
      S_IDLE: begin
        res_we    = s_xfer;
        res_waddr = '0;
        res_wdata = (s_tuser == ACT_CANCEL && id_busy[in_id]) ? in_id : '0;
      end
      S_SCAN: begin
        res_we    = !id_busy[scan_idx];
        res_waddr = '0;
        res_wdata = scan_idx;
      end
      S_CSLOT: hraddr = cnt[IDX_W-1:0];
      S_SU_RD: hraddr = parent;
      S_SU_CMP: begin
        if (t_cur < rd_time) begin
          hwr        = '{en: 1'b1, addr: hole, time_val: rd_time, owner: rd_own};
          slot_we    = 1'b1;
          slot_waddr = rd_own;
          slot_wdata = hole;
        end
      end
      S_SD_RDL: hraddr = child[IDX_W-1:0];
      S_SD_RDR: hraddr = child_r[IDX_W-1:0];
      S_SD_CMP: begin
        if (!(t_cur < c_time)) begin
          hwr        = '{en: 1'b1, addr: hole, time_val: c_time, owner: c_own};
          slot_we    = 1'b1;
          slot_waddr = c_own;
          slot_wdata = hole;
        end
      end
      S_FIN: begin
        hwr        = '{en: 1'b1, addr: hole, time_val: t_cur, owner: own_cur};
        slot_we    = 1'b1;
        slot_waddr = own_cur;
        slot_wdata = hole;
      end
      S_POP_RD: hraddr = '0;
      S_POP_CHK: begin
        hraddr    = cnt_dec[IDX_W-1:0];
        res_we    = (first || rd_time == now) && !n_res[CNT_W-1];
        res_waddr = n_res[IDX_W-1:0];
        res_wdata = rd_own;
      end
      S_TOP_RD: hraddr = '0;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (slot_we) id_slot[slot_waddr] <= slot_wdata;
    slot_rd <= id_slot[in_id];
    if (res_we) res_buf[res_waddr] <= res_wdata;
    res_rd <= res_buf[k_res[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      cnt     <= '0;
      id_busy <= '0;
      n_res   <= '0;
      k_res   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (s_xfer) begin
            act    <= s_tuser;
            exp_in <= s_tdata[TIME_W-1:0];
            status <= ST_OK;
            n_res  <= CNT_W'(1);
            case (s_tuser)
              ACT_INSERT: begin
                if (cnt == CNT_W'(CAPACITY)) begin
                  status <= ST_FULL;
                  state  <= S_TOP_RD;
                end else begin
                  scan_idx <= '0;
                  state    <= S_SCAN;
                end
              end
              ACT_CANCEL: begin
                if (!id_busy[in_id]) begin
                  status <= ST_UNKNOWN;
                  state  <= S_TOP_RD;
                end else begin
                  id_busy[in_id] <= 1'b0;
                  cnt            <= cnt_dec;
                  state          <= S_CSLOT;
                end
              end
              ACT_EXPIRE: begin
                if (cnt == '0) begin
                  status <= ST_EMPTY;
                  state  <= S_TOP_RD;
                end else begin
                  n_res <= '0;
                  first <= 1'b1;
                  state <= S_POP_RD;
                end
              end
              default: ;
            endcase
          end
        end
        S_SCAN: begin
          if (!id_busy[scan_idx]) begin
            id_busy[scan_idx] <= 1'b1;
            own_cur  <= scan_idx;
            t_cur    <= exp_in;
            hole     <= cnt[IDX_W-1:0];
            cnt      <= cnt + CNT_W'(1);
            after_up <= 1'b0;
            state    <= S_SU_RD;
          end else begin
            scan_idx <= scan_idx + IDX_W'(1);
          end
        end
        S_CSLOT: begin
          // fill the vacated slot with the last entry unless it was the last
          if ({1'b0, slot_rd} < cnt) begin
            hole     <= slot_rd;
            after_up <= 1'b1;
            state    <= S_CLAST;
          end else begin
            state <= S_TOP_RD;
          end
        end
        S_CLAST: begin
          t_cur   <= rd_time;
          own_cur <= rd_own;
          state   <= S_SU_RD;
        end
        S_SU_RD: begin
          if (hole == '0) state <= after_up ? S_SD_RDL : S_FIN;
          else            state <= S_SU_CMP;
        end
        S_SU_CMP: begin
          if (t_cur < rd_time) begin
            hole  <= parent;
            state <= S_SU_RD;
          end else begin
            state <= after_up ? S_SD_RDL : S_FIN;
          end
        end
        S_SD_RDL: begin
          if (child >= cnt) state <= S_FIN;
          else              state <= S_SD_RDR;
        end
        S_SD_RDR: begin
          l_time <= rd_time;
          l_own  <= rd_own;
          r_ok   <= child_r < {1'b0, cnt};
          state  <= S_SD_CMP;
        end
        S_SD_CMP: begin
          if (t_cur < c_time) begin
            state <= S_FIN;
          end else begin
            hole  <= c_idx;
            state <= S_SD_RDL;
          end
        end
        S_FIN: state <= (act == ACT_EXPIRE) ? S_POP_RD : S_TOP_RD;
        S_POP_RD: state <= (cnt == '0) ? S_TOP_RD : S_POP_CHK;
        S_POP_CHK: begin
          if ((first || rd_time == now) && !n_res[CNT_W-1]) begin
            if (first) now <= rd_time;
            first           <= 1'b0;
            n_res           <= n_res + CNT_W'(1);
            id_busy[rd_own] <= 1'b0;
            cnt             <= cnt_dec;
            hole            <= '0;
            after_up        <= 1'b1;
            state           <= (cnt_dec != '0) ? S_CLAST : S_TOP_RD;
          end else begin
            state <= S_TOP_RD;
          end
        end
        S_TOP_RD: state <= S_TOP_GET;
        S_TOP_GET: begin
          earl  <= (cnt != '0) ? rd_time : '0;
          k_res <= '0;
          state <= S_OUT_RD;
        end
        S_OUT_RD: state <= S_OUT_SHOW;
        S_OUT_SHOW: begin
          if (m_tready) begin
            k_res <= k_res + CNT_W'(1);
            state <= (k_res + CNT_W'(1) == n_res) ? S_IDLE : S_OUT_RD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_tvalid = (state == S_OUT_SHOW);
  assign m_tlast  = (k_res + CNT_W'(1) == n_res);
  assign m_tdata  = {cnt,
                     (cnt != '0),
                     earl,
                     (act == ACT_EXPIRE && status == ST_OK) ? now : '0,
                     res_rd,
                     status};

endmodule
